[hdl/assert_macros.svh]
// Assertion macros shared by the base64 encoder RTL.
// No dependencies; included inside module bodies after clk and rst_n exist.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define B64_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define B64_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hdl/b64_pkg.sv]
// Types, constants and the alphabet mapping for the base64 encoder.
// No dependencies.
package b64_pkg;

    localparam logic [6:0] PAD_CHAR = 7'h3D;
    localparam int         GROUP_CHARS = 4;

    typedef logic [5:0] sextet_t;
    typedef logic [1:0] char_idx_t;

    // One queued word: the characters produced by one input byte.
    typedef struct packed {
        sextet_t [GROUP_CHARS-1:0] sym;
        logic [GROUP_CHARS-1:0]    pad;
        char_idx_t                 last_idx;
        logic                      fin;
    } code_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [6:0] b64_char(input sextet_t v);
        logic [6:0] x;
        x = {1'b0, v};
        if (v < 6'd26)
            b64_char = x + 7'h41;
        else if (v < 6'd52)
            b64_char = x - 7'd26 + 7'h61;
        else if (v < 6'd62)
            b64_char = x - 7'd52 + 7'h30;
        else if (v == 6'd62)
            b64_char = 7'h2B;
        else
            b64_char = 7'h2F;
    endfunction

endpackage

[hdl/b64_front.sv]
// Front end: accepts bytes, tracks group phase, builds queue words.
// Depends on b64_pkg.
module b64_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 last_byte,
    output b64_pkg::code_entry_t entry
);
    import b64_pkg::*;

    typedef enum logic [2:0] {
        PH0 = 3'b001,
        PH1 = 3'b010,
        PH2 = 3'b100
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    always_comb
    begin
        entry      = '0;
        entry.fin  = last_byte;
        phase_next = phase_reg;
        held_next  = held_reg;
        case (phase_reg)
            PH1:
            begin
                entry.sym[0] = {held_reg[1:0], in_byte[7:4]};
                if (last_byte)
                begin
                    entry.sym[1]   = {in_byte[3:0], 2'b00};
                    entry.pad[2]   = 1'b1;
                    entry.last_idx = 2'd2;
                    phase_next     = PH0;
                    held_next      = '0;
                end
                else
                begin
                    entry.last_idx = 2'd0;
                    phase_next     = PH2;
                    held_next      = in_byte;
                end
            end
            PH2:
            begin
                entry.sym[0]   = {held_reg[3:0], in_byte[7:6]};
                entry.sym[1]   = in_byte[5:0];
                entry.last_idx = 2'd1;
                phase_next     = PH0;
                held_next      = '0;
            end
            default:
            begin
                entry.sym[0] = in_byte[7:2];
                if (last_byte)
                begin
                    entry.sym[1]   = {in_byte[1:0], 4'b0000};
                    entry.pad[2]   = 1'b1;
                    entry.pad[3]   = 1'b1;
                    entry.last_idx = 2'd3;
                    phase_next     = PH0;
                    held_next      = '0;
                end
                else
                begin
                    entry.last_idx = 2'd0;
                    phase_next     = PH1;
                    held_next      = in_byte;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH0;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

[hdl/b64_queue.sv]
// Short queue of code words between front and back end.
// Depends on b64_pkg and assert_macros.svh.
module b64_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  b64_pkg::code_entry_t push_entry,
    input  logic                 pop,
    output b64_pkg::code_entry_t head,
    output b64_pkg::q_stat_t     stat
);
    import b64_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    code_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        wrap_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign head       = mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`include "assert_macros.svh"

    `B64_NEVER(a_push_full, push && stat.full, "push into full queue")
    `B64_NEVER(a_pop_empty, pop && stat.empty, "pop from empty queue")
    `B64_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count overflow")

endmodule

[hdl/b64_back.sv]
// Back end: walks the characters of the head word into the output register.
// Depends on b64_pkg and assert_macros.svh.
module b64_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b64_pkg::code_entry_t head,
    input  logic                 q_empty,
    output logic                 pop,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [6:0]           out_char,
    output logic                 last_char
);
    import b64_pkg::*;

    char_idx_t  idx_reg;
    logic       out_valid_reg;
    logic [6:0] out_char_reg;
    logic       last_char_reg;
    logic       load;
    logic       at_end;

    assign load   = (!out_valid_reg || !out_stall) && !q_empty;
    assign at_end = (idx_reg == head.last_idx);
    assign pop    = load && at_end;

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign last_char = last_char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                idx_reg <= at_end ? '0 : idx_reg + 1'b1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_char_reg  <= head.pad[idx_reg] ? PAD_CHAR : b64_char(head.sym[idx_reg]);
            last_char_reg <= head.fin && at_end;
        end
    end

`include "assert_macros.svh"

    `B64_ASSERT(a_idx_range, !q_empty |-> idx_reg <= head.last_idx, "char index past word end")
    `B64_ASSERT(a_idx_idle, q_empty |-> idx_reg == '0, "char index left over on empty queue")

endmodule

[hdl/base64_stream_encoder.sv]
// Top level of the streaming base64 encoder: front end, word queue, back end.
// Depends on b64_pkg, b64_front, b64_queue, b64_back.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   input   | in_valid in_stall in_byte       | in
//           | last_byte                       |
//   output  | out_valid out_stall out_char    | out
//           | last_char                       |
//
// A byte is taken every cycle while the queue has room; the one-character output
// register then sets the sustained rate: one character per byte in phases 0/1, two in
// phase 2, three or four on a last byte in phase 1 or 0.
// An accepted byte is written into the queue; its first character is then registered in the output register.
// Reset clears phase, held byte, queue pointers and output valid.
// out_stall backs up the queue; in_stall is high only while the queue is full.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] out_char,
    output logic       last_char
);
    import b64_pkg::*;

    code_entry_t entry;
    code_entry_t head;
    q_stat_t     stat;
    logic        accept;
    logic        pop;

    assign in_stall = stat.full;
    assign accept   = in_valid && !stat.full;

    b64_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .entry     (entry)
    );

    b64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_entry (entry),
        .pop        (pop),
        .head       (head),
        .stat       (stat)
    );

    b64_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (stat.empty),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_char  (out_char),
        .last_char (last_char)
    );

endmodule

[dv/base64_stream_checker.sv]
// Checker for base64_stream_encoder: watches both channels, predicts the characters
// of every accepted word and compares each accepted output word against them.
// Depends on b64_pkg (sextet_t, PAD_CHAR).
module base64_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       last_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [6:0] out_char,
    input  logic       last_char,
    output int         err_count,
    output int         pending
);
    import b64_pkg::*;

    typedef struct packed {
        logic [6:0] code;
        logic       fin;
    } enc_char_t;

    localparam logic [8*64-1:0] SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    enc_char_t  char_q[$];
    logic [1:0] group_pos  = '0;
    logic [7:0] carry_byte = '0;
    int         errors     = 0;

    function automatic logic [6:0] to_ascii(input sextet_t v);
        to_ascii = SYMBOLS[8 * (63 - int'(v)) +: 7];
    endfunction

    function automatic void queue_char(input logic [6:0] code, input logic fin);
        char_q.insert(char_q.size(), enc_char_t'({code, fin}));
    endfunction

    // Characters completed by one input byte; partial group flushed on the last byte.
    function automatic void predict_chars(input logic [7:0] b, input logic fin);
        case (group_pos)
            2'd1:
            begin
                queue_char(to_ascii({carry_byte[1:0], b[7:4]}), 1'b0);
                if (fin)
                begin
                    queue_char(to_ascii({b[3:0], 2'b00}), 1'b0);
                    queue_char(PAD_CHAR, 1'b1);
                end
                else
                begin
                    carry_byte = b;
                    group_pos  = 2'd2;
                end
            end
            2'd2:
            begin
                queue_char(to_ascii({carry_byte[3:0], b[7:6]}), 1'b0);
                queue_char(to_ascii(b[5:0]), fin);
                carry_byte = '0;
                group_pos  = '0;
            end
            default:
            begin
                // unreachable phase three falls in here as well
                queue_char(to_ascii(b[7:2]), 1'b0);
                if (fin)
                begin
                    queue_char(to_ascii({b[1:0], 4'b0000}), 1'b0);
                    queue_char(PAD_CHAR, 1'b0);
                    queue_char(PAD_CHAR, 1'b1);
                end
                else
                begin
                    carry_byte = b;
                    group_pos  = 2'd1;
                end
            end
        endcase
        if (fin)
        begin
            carry_byte = '0;
            group_pos  = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        enc_char_t want;
        if (!rst_n)
        begin
            char_q.delete();
            group_pos  = '0;
            carry_byte = '0;
            errors     = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (char_q.size() == 0)
                begin
                    errors++;
                    $error("unexpected word: out_char %0h last_char %0b", out_char, last_char);
                end
                else
                begin
                    want = char_q.pop_front();
                    if (want.code !== out_char)
                    begin
                        errors++;
                        $error("out_char: expected %0h, actual %0h", want.code, out_char);
                    end
                    if (want.fin !== last_char)
                    begin
                        errors++;
                        $error("last_char: expected %0b, actual %0b", want.fin, last_char);
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_chars(in_byte, last_byte);
        end
        err_count <= errors;
        pending   <= char_q.size();
    end

endmodule

[dv/base64_stream_encoder_test.sv]
// Testbench top for base64_stream_encoder: clock, reset, byte stimulus, output stall
// pattern, watchdog and verdict. Depends on the encoder RTL and base64_stream_checker.
module base64_stream_encoder_test;

    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte   = '0;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [6:0] out_char;
    logic       last_char;

    int err_count;
    int pending;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int idle_cycles = 0;
    int bytes_sent  = 0;
    bit hold_req    = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    base64_stream_encoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last_char (last_char)
    );

    base64_stream_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .last_char (last_char),
        .err_count (err_count),
        .pending   (pending)
    );

    initial
    begin : receiver
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
        else
            idle_cycles <= 0;
    end

    task automatic send_word(input logic [7:0] b, input logic fin);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        last_byte <= fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    // pattern holds up to four bytes, first byte in the top bits
    task automatic send_msg(input int len, input logic [31:0] pattern, input bit rnd);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            b = rnd ? 8'($urandom) : pattern[31 - 8 * i -: 8];
            send_word(b, i == len - 1);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic random_msgs(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_msg(($urandom_range(0, 3) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6),
                     '0, 1'b1);
    endtask

    initial
    begin : stimulus
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = 15;
        rx_idle_pct = 84;

        // flush after one, two, three and four bytes, extreme values, '+' and '/'
        send_msg(1, 32'h0000_0000, 1'b0);
        send_msg(1, 32'hFF00_0000, 1'b0);
        send_msg(1, 32'hFC00_0000, 1'b0);
        send_msg(2, 32'h00FF_0000, 1'b0);
        send_msg(2, 32'hFF00_0000, 1'b0);
        send_msg(3, 32'h0000_0000, 1'b0);
        send_msg(3, 32'hFFFF_FF00, 1'b0);
        send_msg(3, 32'hFBEF_BE00, 1'b0);
        send_msg(4, 32'h4D61_6EFF, 1'b0);
        drain();

        random_msgs(22);

        tx_idle_pct = 84;
        rx_idle_pct = 15;
        random_msgs(22);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        drain();

        // long output hold while words keep coming, so the input backs up
        hold_req = 1'b1;
        send_msg(12, '0, 1'b1);
        random_msgs(16);

        drain();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
